@@ design/sskvt_pkg.sv @@
// ----------------------------------------------------------------------------
// sskvt_pkg
// shared types and operation codes of the sparse set key/value table
// ----------------------------------------------------------------------------
package sskvt_pkg;

    localparam int OP_BITS = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } sskvt_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPARSE,
        ST_CHECK,
        ST_MOVE
    } sskvt_state_t;

endpackage

@@ design/sskvt_ram.sv @@
// ----------------------------------------------------------------------------
// sskvt_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module sskvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sskvt_engine.sv @@
// ----------------------------------------------------------------------------
// sskvt_engine
// operation sequencer: sparse read, dense read and check, optional move of
// the last dense entry on remove, result register
// ----------------------------------------------------------------------------
module sskvt_engine
    import sskvt_pkg::*;
#(
    parameter int KEY_BITS   = 12,
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32,
    parameter int IDX_BITS   = $clog2(CAPACITY),
    parameter int CNT_BITS   = $clog2(CAPACITY + 1),
    parameter int IN_W       = OP_BITS + KEY_BITS + VALUE_BITS,
    parameter int IN_TW      = ((IN_W + 7) / 8) * 8,
    parameter int OUT_W      = 2 + VALUE_BITS + CNT_BITS,
    parameter int OUT_TW     = ((OUT_W + 7) / 8) * 8,
    parameter int DN_W       = KEY_BITS + VALUE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_TW-1:0]    s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_TW-1:0]   m_tdata,
    output logic [KEY_BITS-1:0] sp_raddr,
    input  logic [IDX_BITS-1:0] sp_rdata,
    output logic                sp_we,
    output logic [KEY_BITS-1:0] sp_waddr,
    output logic [IDX_BITS-1:0] sp_wdata,
    output logic [IDX_BITS-1:0] dn_raddr,
    input  logic [DN_W-1:0]     dn_rdata,
    output logic                dn_we,
    output logic [IDX_BITS-1:0] dn_waddr,
    output logic [DN_W-1:0]     dn_wdata
);

    sskvt_state_t            state_reg, state_next;
    sskvt_op_t               op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic [IDX_BITS-1:0]     slot_reg, slot_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_data_reg, m_data_next;
    logic                    load_out;

    logic                    accept;
    logic                    out_free;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_val;
    logic                    hit_now;
    logic                    full;
    logic [IDX_BITS-1:0]     last_idx;
    logic                    found;
    logic                    status;
    logic [VALUE_BITS-1:0]   vout;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_key   = dn_rdata[DN_W-1:VALUE_BITS];
    assign rd_val   = dn_rdata[VALUE_BITS-1:0];
    assign hit_now  = (CNT_BITS'(slot_reg) < count_reg) && (rd_key == key_reg);
    assign full     = (count_reg == CNT_BITS'(CAPACITY));
    assign last_idx = IDX_BITS'(count_reg - CNT_BITS'(1));

    assign s_tready = (state_reg == ST_IDLE);
    assign sp_raddr = s_tdata[OP_BITS +: KEY_BITS];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'(m_data_reg);

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        load_out   = 1'b0;
        found      = 1'b0;
        status     = 1'b0;
        vout       = '0;
        dn_raddr   = slot_reg;
        sp_we      = 1'b0;
        sp_waddr   = key_reg;
        sp_wdata   = IDX_BITS'(count_reg);
        dn_we      = 1'b0;
        dn_waddr   = slot_reg;
        dn_wdata   = {key_reg, val_reg};

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SPARSE;
                end
            end
            ST_SPARSE: begin
                slot_next  = sp_rdata;
                dn_raddr   = sp_rdata;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                found = hit_now;
                if (op_reg == OP_REMOVE && hit_now) begin
                    dn_raddr   = last_idx;
                    state_next = ST_MOVE;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_ADD: begin
                            if (hit_now) begin
                                dn_we = 1'b1;
                            end else if (full) begin
                                status = 1'b1;
                            end else begin
                                dn_we      = 1'b1;
                                dn_waddr   = IDX_BITS'(count_reg);
                                sp_we      = 1'b1;
                                count_next = count_reg + CNT_BITS'(1);
                            end
                        end
                        OP_LOOKUP: begin
                            if (hit_now) begin
                                vout = rd_val;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MOVE: begin
                found    = 1'b1;
                dn_raddr = last_idx;
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    dn_we      = 1'b1;
                    dn_wdata   = dn_rdata;
                    sp_we      = 1'b1;
                    sp_waddr   = rd_key;
                    sp_wdata   = slot_reg;
                    count_next = count_reg - CNT_BITS'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_data_next = {count_next, vout, status, found};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= sskvt_op_t'(s_tdata[OP_BITS-1:0]);
            key_reg <= s_tdata[OP_BITS +: KEY_BITS];
            val_reg <= s_tdata[OP_BITS + KEY_BITS +: VALUE_BITS];
        end
        slot_reg <= slot_next;
        if (load_out) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

@@ design/sparse_set_key_value_table_core.sv @@
// ----------------------------------------------------------------------------
// sparse_set_key_value_table_core
// sparse set mapping keys to values: sparse index ram addressed by key, dense
// key/value ram, live count; add, remove with swap of the last entry, lookup
// and clear
//
// channel  dir  fields (tdata, lsb first)
// s_       in   opcode[1:0], key[KEY_BITS], value_in[VALUE_BITS], zero pad
// m_       out  found, status, value_out[VALUE_BITS], entry_count, zero pad
//
// the sparse ram is read, then the dense ram in the check state. the result
// register loads from the check state for add, lookup, clear and remove of
// an absent key, from the move state for remove of a present key (second
// dense ram read of the last entry). one operation is in flight at a time;
// a new transfer is taken while the previous result waits. a stalled result
// port holds the sequencer in its final state. the rams need no clearing
// after reset: only the live count is reset.
// ----------------------------------------------------------------------------
module sparse_set_key_value_table_core
    import sskvt_pkg::*;
#(
    parameter int KEY_BITS   = 12,
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // opcode, key, value_in
    input  logic [((OP_BITS + KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // found, status, value_out, entry_count
    output logic [((2 + VALUE_BITS + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int IN_TW    = ((OP_BITS + KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TW   = ((2 + VALUE_BITS + CNT_BITS + 7) / 8) * 8;
    localparam int DN_W     = KEY_BITS + VALUE_BITS;

    logic [KEY_BITS-1:0] sp_raddr;
    logic [IDX_BITS-1:0] sp_rdata;
    logic                sp_we;
    logic [KEY_BITS-1:0] sp_waddr;
    logic [IDX_BITS-1:0] sp_wdata;
    logic [IDX_BITS-1:0] dn_raddr;
    logic [DN_W-1:0]     dn_rdata;
    logic                dn_we;
    logic [IDX_BITS-1:0] dn_waddr;
    logic [DN_W-1:0]     dn_wdata;

    sskvt_ram #(
        .WIDTH     (IDX_BITS),
        .DEPTH     (1 << KEY_BITS),
        .ADDR_BITS (KEY_BITS)
    ) u_sparse_ram (
        .aclk  (aclk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    sskvt_ram #(
        .WIDTH     (DN_W),
        .DEPTH     (CAPACITY),
        .ADDR_BITS (IDX_BITS)
    ) u_dense_ram (
        .aclk  (aclk),
        .we    (dn_we),
        .waddr (dn_waddr),
        .wdata (dn_wdata),
        .raddr (dn_raddr),
        .rdata (dn_rdata)
    );

    sskvt_engine #(
        .KEY_BITS   (KEY_BITS),
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .IDX_BITS   (IDX_BITS),
        .CNT_BITS   (CNT_BITS),
        .IN_TW      (IN_TW),
        .OUT_TW     (OUT_TW),
        .DN_W       (DN_W)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .sp_raddr (sp_raddr),
        .sp_rdata (sp_rdata),
        .sp_we    (sp_we),
        .sp_waddr (sp_waddr),
        .sp_wdata (sp_wdata),
        .dn_raddr (dn_raddr),
        .dn_rdata (dn_rdata),
        .dn_we    (dn_we),
        .dn_waddr (dn_waddr),
        .dn_wdata (dn_wdata)
    );

endmodule
